### hw/rtl/owm_pkg.sv
package owm_pkg;

  localparam int unsigned TickW    = 10;
  localparam int unsigned ShortW   = 8;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [TickW-1:0]  ResetLowDef   = 10'd350;
  localparam logic [TickW-1:0]  ResetWaitDef  = 10'd265;
  localparam logic [ShortW-1:0] ResetLeadDef  = 8'd1;
  localparam logic [ShortW-1:0] WriteLeadDef  = 8'd1;
  localparam logic [ShortW-1:0] ReadLeadDef   = 8'd2;
  localparam logic [ShortW-1:0] SlotHoldDef   = 8'd40;
  localparam logic [ShortW-1:0] RecoveryDef   = 8'd1;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdReset = 2'd1,
    CmdWrite = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RegResetLow  = 3'd0,
    RegResetWait = 3'd1,
    RegResetLead = 3'd2,
    RegWriteLead = 3'd3,
    RegReadLead  = 3'd4,
    RegSlotHold  = 3'd5,
    RegRecovery  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0]  reset_low_ticks;
    logic [TickW-1:0]  reset_wait_ticks;
    logic [ShortW-1:0] reset_lead_ticks;
    logic [ShortW-1:0] write_lead_ticks;
    logic [ShortW-1:0] read_lead_ticks;
    logic [ShortW-1:0] slot_hold_ticks;
    logic [ShortW-1:0] recovery_ticks;
  } cfg_t;

  typedef struct packed {
    cmd_e             kind;
    logic [DataW-1:0] data;
    logic             line_level;
  } item_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] read_data;
    logic             rejected;
  } res_t;

endpackage

### hw/rtl/owm_if.sv
interface owm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data;
  logic       line_level;

  modport source (output valid, output op, output data, output line_level, input ready);
  modport sink (input valid, input op, input data, input line_level, output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       rejected;

  modport source (
    output valid, output drive_low, output busy_res, output done_res,
    output read_data, output rejected, input ready
  );
  modport sink (
    input valid, input drive_low, input busy_res, input done_res,
    input read_data, input rejected, output ready
  );
endinterface

### hw/rtl/owm_cfg.sv
module owm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [owm_pkg::CfgAddrW-1:0]   paddr,
  input  logic [owm_pkg::CfgDataW-1:0]   pwdata,
  output logic [owm_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  output owm_pkg::cfg_t                  cfg_o
);
  import owm_pkg::*;

  cfg_t     cfg_q;
  cfg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = cfg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks  <= ResetLowDef;
      cfg_q.reset_wait_ticks <= ResetWaitDef;
      cfg_q.reset_lead_ticks <= ResetLeadDef;
      cfg_q.write_lead_ticks <= WriteLeadDef;
      cfg_q.read_lead_ticks  <= ReadLeadDef;
      cfg_q.slot_hold_ticks  <= SlotHoldDef;
      cfg_q.recovery_ticks   <= RecoveryDef;
    end else if (wr_en) begin
      case (reg_idx)
        RegResetLow:  cfg_q.reset_low_ticks  <= pwdata[TickW-1:0];
        RegResetWait: cfg_q.reset_wait_ticks <= pwdata[TickW-1:0];
        RegResetLead: cfg_q.reset_lead_ticks <= pwdata[ShortW-1:0];
        RegWriteLead: cfg_q.write_lead_ticks <= pwdata[ShortW-1:0];
        RegReadLead:  cfg_q.read_lead_ticks  <= pwdata[ShortW-1:0];
        RegSlotHold:  cfg_q.slot_hold_ticks  <= pwdata[ShortW-1:0];
        RegRecovery:  cfg_q.recovery_ticks   <= pwdata[ShortW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegResetLow:  prdata = CfgDataW'(cfg_q.reset_low_ticks);
      RegResetWait: prdata = CfgDataW'(cfg_q.reset_wait_ticks);
      RegResetLead: prdata = CfgDataW'(cfg_q.reset_lead_ticks);
      RegWriteLead: prdata = CfgDataW'(cfg_q.write_lead_ticks);
      RegReadLead:  prdata = CfgDataW'(cfg_q.read_lead_ticks);
      RegSlotHold:  prdata = CfgDataW'(cfg_q.slot_hold_ticks);
      RegRecovery:  prdata = CfgDataW'(cfg_q.recovery_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/owm_front.sv
module owm_front #(
  parameter int unsigned Depth = owm_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  owm_cmd_if.sink        cmd,
  output logic           item_valid_o,
  output owm_pkg::item_t item_o,
  input  logic           pop_i
);
  import owm_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           q_mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  item_t           item_in;
  logic            push, pop;

  assign cmd.ready    = (cnt_q != CntW'(Depth));
  assign push         = cmd.valid && cmd.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    item_in.kind       = cmd_e'(cmd.op);
    item_in.data       = (cmd.op == CmdWrite) ? cmd.data : '0;
    item_in.line_level = cmd.line_level;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("Queue count exceeds its depth.");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("Queue count did not drop on a pop.");

endmodule

### hw/rtl/owm_engine.sv
module owm_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  owm_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  owm_pkg::item_t item_i,
  output logic           pop_o,
  owm_res_if.source      res
);
  import owm_pkg::*;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhRstLead = 3'd1,
    PhRstLow  = 3'd2,
    PhRstWait = 3'd3,
    PhLead    = 3'd4,
    PhHold    = 3'd5,
    PhRec     = 3'd6
  } phase_e;

  phase_e           phase_q, phase_d;
  cmd_e             cmd_q, cmd_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [2:0]       bit_q, bit_d;
  logic [DataW-1:0] shift_q, shift_d;
  logic [DataW-1:0] last_q, last_d;
  logic             res_valid_q;
  res_t             res_q, res_d;

  logic [TickW-1:0] tick_inc, len;
  logic             drive, rej, done, fin, adv_slot;

  function automatic logic [TickW-1:0] min_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

  assign pop_o = item_valid_i && (!res_valid_q || res.ready);

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    last_d   = last_q;
    drive    = 1'b0;
    rej      = 1'b0;
    done     = 1'b0;
    fin      = 1'b0;
    adv_slot = 1'b0;
    tick_inc = '0;
    len      = TickW'(1);

    if (item_i.kind != CmdTick) begin
      if (phase_d != PhIdle) begin
        rej = 1'b1;
      end else begin
        cmd_d  = item_i.kind;
        bit_d  = '0;
        tick_d = '0;
        if (item_i.kind == CmdReset) begin
          phase_d = (cfg_i.reset_lead_ticks == '0) ? PhRstLow : PhRstLead;
        end else begin
          shift_d = (item_i.kind == CmdWrite) ? item_i.data : '0;
          phase_d = PhLead;
        end
      end
    end

    if (phase_d != PhIdle) begin
      if (phase_d == PhRstLow || phase_d == PhLead) begin
        drive = 1'b1;
      end else if (phase_d == PhHold && cmd_d == CmdWrite) begin
        drive = ~shift_d[0];
      end

      if (phase_d == PhHold && cmd_d == CmdRead && tick_d == '0) begin
        shift_d = {item_i.line_level, shift_d[DataW-1:1]};
      end

      tick_inc = tick_d + TickW'(1);
      case (phase_d)
        PhRstLead: len = TickW'(cfg_i.reset_lead_ticks);
        PhRstLow:  len = min_one(cfg_i.reset_low_ticks);
        PhRstWait: len = min_one(cfg_i.reset_wait_ticks);
        PhLead:    len = min_one((cmd_d == CmdRead) ? TickW'(cfg_i.read_lead_ticks)
                                                    : TickW'(cfg_i.write_lead_ticks));
        PhHold:    len = min_one(TickW'(cfg_i.slot_hold_ticks));
        PhRec:     len = TickW'(cfg_i.recovery_ticks);
        default:   len = TickW'(1);
      endcase

      if (tick_inc >= len) begin
        tick_d = '0;
        case (phase_d)
          PhRstLead: phase_d = PhRstLow;
          PhRstLow:  phase_d = PhRstWait;
          PhRstWait: fin = 1'b1;
          PhLead:    phase_d = PhHold;
          PhHold: begin
            if (cmd_d == CmdWrite) begin
              shift_d = {1'b0, shift_d[DataW-1:1]};
            end
            if (cfg_i.recovery_ticks == '0) begin
              adv_slot = 1'b1;
            end else begin
              phase_d = PhRec;
            end
          end
          PhRec:     adv_slot = 1'b1;
          default:   fin = 1'b1;
        endcase
        if (adv_slot) begin
          if (bit_d == 3'd7) begin
            fin = 1'b1;
          end else begin
            bit_d   = bit_d + 3'd1;
            phase_d = PhLead;
          end
        end
        if (fin) begin
          if (cmd_d == CmdRead) begin
            last_d = shift_d;
          end
          phase_d = PhIdle;
          done    = 1'b1;
        end
      end else begin
        tick_d = tick_inc;
      end
    end

    res_d.drive_low = drive;
    res_d.busy_res  = (phase_d != PhIdle);
    res_d.done_res  = done;
    res_d.read_data = last_d;
    res_d.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cmd_q       <= CmdTick;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      last_q      <= last_d;
      res_valid_q <= 1'b1;
      res_q       <= res_d;
    end else if (res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res.valid     = res_valid_q;
  assign res.drive_low = res_q.drive_low;
  assign res.busy_res  = res_q.busy_res;
  assign res.done_res  = res_q.done_res;
  assign res.read_data = res_q.read_data;
  assign res.rejected  = res_q.rejected;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("A finished operation still reports busy.");

  a_idle_no_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && phase_q == PhIdle) |=> !res_q.rejected)
    else $error("A command was rejected while the engine was idle.");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (tick_q == '0))
    else $error("Tick count is not clear while idle.");

endmodule

### hw/rtl/onewire_master_byte_engine.sv
// Single-wire bus master that times reset pulses and byte writes and reads.
// Commands arrive on the cmd_i channel, one transaction per bus tick: op 0 is
// a plain tick, op 1 starts a reset pulse, op 2 writes data LSB first and op 3
// reads a byte. Each command transaction yields exactly one result transaction
// on res_o with the bus drive level for that tick, busy, done, the last byte
// read and a rejected flag for a command that arrived while busy.
// Timing registers are to be written by the user through the APB port only
// while the engine is idle; the block does not enforce this. A command enters
// a queue of QueueDepth entries, two by default, and its result passes through
// the engine's output register. While res_o does not stall, one transaction is
// accepted and one result is delivered every cycle; that rate is set by the
// engine, which retires one queued tick per cycle into its output register.
// When res_o stalls, the result is held, the queue fills and cmd_i ready drops
// once the queue is full; no transaction is lost.
// Reset loads the default timings, empties the queue, returns the engine to
// idle and clears the stored read byte.
module onewire_master_byte_engine #(
  parameter int unsigned QueueDepth = owm_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [owm_pkg::CfgAddrW-1:0] paddr,
  input  logic [owm_pkg::CfgDataW-1:0] pwdata,
  output logic [owm_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  owm_cmd_if.sink                      cmd_i,
  owm_res_if.source                    res_o
);
  import owm_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  pop;

  owm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owm_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd          (cmd_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  owm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .res          (res_o)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import owm_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned RandPhases = 6;

  typedef enum logic [2:0] {
    BusIdle,
    BusRstLead,
    BusRstLow,
    BusRstWait,
    BusLead,
    BusHold,
    BusRec
  } bus_phase_e;

  typedef enum int {
    LineRandom,
    LineHigh,
    LineLow
  } line_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  owm_cmd_if cmd_if ();
  owm_res_if res_if ();

  onewire_master_byte_engine i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_if),
    .res_o   (res_if)
  );

  // Bus timing as programmed, and the engine state that it drives.
  cfg_t       timing;
  bus_phase_e bus_ph    = BusIdle;
  cmd_e       bus_cmd   = CmdTick;
  logic [9:0] tick_cnt  = '0;
  logic [2:0] bit_idx   = '0;
  logic [7:0] shreg     = '0;
  logic [7:0] last_byte = '0;
  logic       op_done   = 1'b0;

  item_t       bus_cmds_q[$];
  res_t        bus_reports_q[$];
  item_t       cur_cmd;
  bit          jitter_on;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned n_queued;
  int unsigned n_checked;
  int unsigned n_rejected;
  int unsigned n_done;
  int unsigned n_settings;
  int unsigned n_err;

  function automatic int unsigned at_least1(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned phase_ticks();
    case (bus_ph)
      BusRstLead: return 32'(timing.reset_lead_ticks);
      BusRstLow:  return at_least1(32'(timing.reset_low_ticks));
      BusRstWait: return at_least1(32'(timing.reset_wait_ticks));
      BusLead:    return at_least1(32'((bus_cmd == CmdRead) ? timing.read_lead_ticks :
                                                              timing.write_lead_ticks));
      BusHold:    return at_least1(32'(timing.slot_hold_ticks));
      BusRec:     return 32'(timing.recovery_ticks);
      default:    return 1;
    endcase
  endfunction

  function automatic void finish_op();
    if (bus_cmd == CmdRead) begin
      last_byte = shreg;
    end
    bus_ph   = BusIdle;
    tick_cnt = '0;
    op_done  = 1'b1;
  endfunction

  function automatic void next_slot();
    if (bit_idx == 3'd7) begin
      finish_op();
    end else begin
      bit_idx  = bit_idx + 3'd1;
      bus_ph   = BusLead;
      tick_cnt = '0;
    end
  endfunction

  // Empty phases (no reset lead, no recovery) are passed over at once.
  function automatic void enter_phase(bus_phase_e p);
    bus_ph   = p;
    tick_cnt = '0;
    if (p == BusRstLead && timing.reset_lead_ticks == 0) begin
      bus_ph = BusRstLow;
    end else if (p == BusRec && timing.recovery_ticks == 0) begin
      next_slot();
    end
  endfunction

  function automatic res_t advance_bus_tick(item_t it);
    res_t r;
    r       = '0;
    op_done = 1'b0;
    if (it.kind != CmdTick) begin
      if (bus_ph != BusIdle) begin
        r.rejected = 1'b1;
      end else begin
        bus_cmd = it.kind;
        bit_idx = '0;
        if (it.kind == CmdReset) begin
          enter_phase(BusRstLead);
        end else begin
          shreg = (it.kind == CmdWrite) ? it.data : 8'h00;
          enter_phase(BusLead);
        end
      end
    end
    if (bus_ph != BusIdle) begin
      if (bus_ph == BusRstLow || bus_ph == BusLead) begin
        r.drive_low = 1'b1;
      end else if (bus_ph == BusHold && bus_cmd == CmdWrite) begin
        r.drive_low = ~shreg[0];
      end
      if (bus_ph == BusHold && bus_cmd == CmdRead && tick_cnt == 0) begin
        shreg = {it.line_level, shreg[7:1]};
      end
      tick_cnt = tick_cnt + 10'd1;
      if (32'(tick_cnt) >= phase_ticks()) begin
        case (bus_ph)
          BusRstLead: enter_phase(BusRstLow);
          BusRstLow:  enter_phase(BusRstWait);
          BusRstWait: finish_op();
          BusLead:    enter_phase(BusHold);
          BusHold: begin
            if (bus_cmd == CmdWrite) begin
              shreg = shreg >> 1;
            end
            enter_phase(BusRec);
          end
          BusRec:     next_slot();
          default:    finish_op();
        endcase
      end
    end
    r.busy_res  = (bus_ph != BusIdle);
    r.done_res  = op_done;
    r.read_data = last_byte;
    return r;
  endfunction

  function automatic int unsigned op_ticks(cmd_e k);
    if (k == CmdReset) begin
      return 32'(timing.reset_lead_ticks) + at_least1(32'(timing.reset_low_ticks)) +
             at_least1(32'(timing.reset_wait_ticks));
    end
    return 8 * (at_least1(32'((k == CmdRead) ? timing.read_lead_ticks :
                                               timing.write_lead_ticks)) +
                at_least1(32'(timing.slot_hold_ticks)) + 32'(timing.recovery_ticks));
  endfunction

  function automatic logic line_bit(line_mode_e mode);
    case (mode)
      LineHigh: return 1'b1;
      LineLow:  return 1'b0;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic void push_item(cmd_e k, logic [7:0] d, logic l);
    item_t it;
    it.kind       = k;
    it.data       = d;
    it.line_level = l;
    bus_cmds_q.push_back(it);
    n_queued++;
  endfunction

  function automatic void push_ticks(int unsigned n, line_mode_e mode, bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        push_item(cmd_e'($urandom_range(1, 3)), 8'($urandom), line_bit(mode));
      end else begin
        push_item(CmdTick, 8'($urandom), line_bit(mode));
      end
    end
  endfunction

  // A cut operation may be followed early by the next command, landing while busy.
  function automatic void run_op(cmd_e k, logic [7:0] d, line_mode_e mode, bit noisy, bit cut);
    int unsigned n;
    n = op_ticks(k);
    if (cut) begin
      n = $urandom_range(1, n);
    end
    push_item(k, d, line_bit(mode));
    push_ticks(n - 1, mode, noisy);
  endfunction

  function automatic cfg_t rand_timing();
    cfg_t c;
    c.reset_low_ticks  = 10'($urandom_range(1, 12));
    c.reset_wait_ticks = 10'($urandom_range(1, 12));
    c.reset_lead_ticks = 8'($urandom_range(0, 3));
    c.write_lead_ticks = 8'($urandom_range(1, 3));
    c.read_lead_ticks  = 8'($urandom_range(1, 3));
    c.slot_hold_ticks  = 8'($urandom_range(1, 6));
    c.recovery_ticks   = 8'($urandom_range(0, 2));
    return c;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      n_err++;
      if (n_err <= 50) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      end
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_timing(cfg_t c);
    write_reg(RegResetLow, CfgDataW'(c.reset_low_ticks));
    write_reg(RegResetWait, CfgDataW'(c.reset_wait_ticks));
    write_reg(RegResetLead, CfgDataW'(c.reset_lead_ticks));
    write_reg(RegWriteLead, CfgDataW'(c.write_lead_ticks));
    write_reg(RegReadLead, CfgDataW'(c.read_lead_ticks));
    write_reg(RegSlotHold, CfgDataW'(c.slot_hold_ticks));
    write_reg(RegRecovery, CfgDataW'(c.recovery_ticks));
    timing = c;
    n_settings++;
    @(negedge clk_i);
  endtask

  // Waits until every transaction has been answered and the engine is idle again.
  task automatic settle_bus();
    forever begin
      while (bus_cmds_q.size() != 0 || cmd_if.valid || bus_reports_q.size() != 0) begin
        @(negedge clk_i);
      end
      if (bus_ph == BusIdle) begin
        break;
      end
      push_ticks(4, LineRandom, 1'b0);
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.op         <= CmdTick;
      cmd_if.data       <= '0;
      cmd_if.line_level <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        bus_reports_q.push_back(advance_bus_tick(cur_cmd));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          cmd_if.valid <= 1'b0;
        end else if (bus_cmds_q.size() != 0) begin
          cur_cmd = bus_cmds_q.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.op         <= cur_cmd.kind;
          cmd_if.data       <= cur_cmd.data;
          cmd_if.line_level <= cur_cmd.line_level;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || !jitter_on) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (bus_reports_q.size() == 0) begin
        n_err++;
        $display("%0t: result transaction with nothing expected", $time);
      end else begin
        want = bus_reports_q.pop_front();
        n_checked++;
        n_rejected += 32'(want.rejected);
        n_done     += 32'(want.done_res);
        check_field("drive_low", 32'(want.drive_low), 32'(res_if.drive_low));
        check_field("busy", 32'(want.busy_res), 32'(res_if.busy_res));
        check_field("done", 32'(want.done_res), 32'(res_if.done_res));
        check_field("read_data", 32'(want.read_data), 32'(res_if.read_data));
        check_field("rejected", 32'(want.rejected), 32'(res_if.rejected));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned goal;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.op         = CmdTick;
    cmd_if.data       = '0;
    cmd_if.line_level = 1'b0;
    res_if.ready      = 1'b0;
    jitter_on         = 1'b1;
    timing = {ResetLowDef, ResetWaitDef, ResetLeadDef, WriteLeadDef, ReadLeadDef,
              SlotHoldDef, RecoveryDef};
    n_settings = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_item(CmdTick, 8'hFF, 1'b1);
    push_item(CmdTick, 8'h00, 1'b0);
    push_item(CmdReset, 8'hFF, 1'b1);
    push_item(CmdWrite, 8'h00, 1'b0);
    push_item(CmdRead, 8'hFF, 1'b0);
    push_item(CmdReset, 8'h55, 1'b1);
    push_ticks(op_ticks(CmdReset) - 4, LineRandom, 1'b0);
    settle_bus();

    program_timing(cfg_t'{10'd1, 10'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0});
    run_op(CmdReset, 8'h00, LineRandom, 1'b0, 1'b0);
    run_op(CmdWrite, 8'hA5, LineRandom, 1'b0, 1'b0);
    run_op(CmdRead, 8'h00, LineRandom, 1'b0, 1'b0);
    run_op(CmdWrite, 8'h3C, LineRandom, 1'b1, 1'b0);
    settle_bus();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      program_timing(rand_timing());
      jitter_on = (ph != 2) && (ph != RandPhases - 1);
      goal = n_queued + PhaseItems;
      while (n_queued < goal) begin
        if ($urandom_range(0, 4) != 0) begin
          run_op(cmd_e'($urandom_range(1, 3)), 8'($urandom), LineRandom, 1'b1,
                 $urandom_range(0, 9) == 0);
        end else begin
          push_ticks($urandom_range(1, 3), LineRandom, 1'b0);
        end
      end
      settle_bus();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d result transactions under %0d timing settings.", n_checked,
             n_settings);
    $display("Operations finished: %0d, commands rejected while busy: %0d.", n_done,
             n_rejected);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
